// ----- rtl/ntc_pkg.sv -----
// ntc_pkg: shared types and constants for the thermistor code-to-temperature core.
// No dependencies.
`default_nettype none

package ntc_pkg;

  localparam int CODE_BITS = 16;

  // converter full scale and the 3.3 V clamp point in code*4096 units
  localparam longint FULL_SCALE = (64'd1 << (CODE_BITS - 1)) - 1;
  localparam logic [26:0] DIV_LIMIT = 27'(3300 * FULL_SCALE);

  localparam logic [25:0] LN2_Q26 = 26'd46516320;
  localparam logic [18:0] KELVIN_CENTI = 19'd27315;
  localparam logic signed [17:0] T_ABS_ZERO = -18'sd27315;
  localparam logic signed [17:0] T_OUT_MAX = 18'sd131071;
  localparam logic signed [17:0] T_OUT_MIN = -18'sd32768;
  localparam logic [63:0] Q_POS_LIMIT = 64'd158386;
  localparam logic [63:0] Q_NEG_LIMIT = 64'd60083;
  localparam logic [63:0] DIV_NUM_BASE = 64'd200 << 48;

  localparam logic [39:0] COEF_A_RST = 40'd272038592043;
  localparam logic [39:0] COEF_B_RST = 40'd56432635466;
  localparam logic [39:0] COEF_D_RST = 40'd47169971;
  localparam logic [19:0] SERIES_RST = 20'd12000;
  localparam logic signed [17:0] MIN_RST = -18'sd2000;
  localparam logic signed [17:0] MAX_RST = 18'sd30000;

  typedef enum logic [2:0] {
    REG_READY,
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_D,
    REG_SERIES,
    REG_MIN,
    REG_MAX
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] adc_code;
    logic               read_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] temperature_centi;
    logic               valid_res;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/ntc_code_to_temperature_core.sv -----
// Thermistor divider readout: converter code to temperature, Steinhart-Hart form.
// Each beat runs the normalize shifts and 30 squarings of each of the two log2 terms on the
// 8-bit digit-serial multiplier, five more products and the 1-bit restoring divider, which
// is skipped when the Steinhart-Hart sum is zero.
// Negative codes, zero or infinite resistance and sensor_ready low all skip the math.
// One beat in flight; the next input can be taken in the cycle after the result is loaded
// into the output register, and that load waits while out_stall holds a pending result.
// Synchronous reset restores register defaults and clears the last good code.
// Depends on ntc_pkg.
`default_nettype none

module ntc_code_to_temperature_core import ntc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [39:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_NORM, S_MUL, S_SQR, S_LN, S_LMAG, S_L2, S_L3,
    S_TD, S_TB, S_SGN, S_DIV, S_QUOT, S_FIN, S_DONE
  } state_t;

  // configuration
  logic                sensor_ready;
  logic [39:0]         coef_a, coef_b, coef_d;
  logic [19:0]         series_ohms;
  logic signed [17:0]  min_plausible, max_plausible;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_ready  <= 1'b0;
      coef_a        <= COEF_A_RST;
      coef_b        <= COEF_B_RST;
      coef_d        <= COEF_D_RST;
      series_ohms   <= SERIES_RST;
      min_plausible <= MIN_RST;
      max_plausible <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_READY:  sensor_ready  <= cfg_data[0];
        REG_COEF_A: coef_a        <= cfg_data;
        REG_COEF_B: coef_b        <= cfg_data;
        REG_COEF_D: coef_d        <= cfg_data;
        REG_SERIES: series_ohms   <= cfg_data[19:0];
        REG_MIN:    min_plausible <= cfg_data[17:0];
        REG_MAX:    max_plausible <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  state_t              state, ret;
  logic [15:0]         last_good_code;
  logic signed [15:0]  code;
  logic                ok;
  logic [26:0]         den;
  logic [47:0]         x;
  logic [5:0]          k;
  logic [29:0]         frac;
  logic [4:0]          icnt;
  logic                which;
  logic [35:0]         lnum, lden, lmag;
  logic                neg;
  logic [57:0]         td;
  logic [63:0]         s;
  logic [63:0]         dvd, dvs, rem;
  logic [5:0]          qcnt;
  logic signed [17:0]  res_t;
  logic                res_v;

  // digit-serial multiplier: 48 x 48, 8 bits of mul_b per cycle
  logic [47:0]         mul_a, mul_b, mul_hi, mul_lo;
  logic [2:0]          mcnt;
  logic [55:0]         mul_sum;
  logic [95:0]         prod;

  assign mul_sum = {8'b0, mul_hi} + 56'(mul_a) * 56'(mul_b[7:0]);
  assign prod    = {mul_hi, mul_lo};

  // prep terms
  logic [34:0]         sc;
  logic [26:0]         code4096;
  logic                special;
  assign sc       = 35'(series_ohms) * 35'(code[14:0]);
  assign code4096 = {code[14:0], 12'b0};
  assign special  = code[15] || (code == 16'sd0) || (series_ohms == 20'd0) ||
                    (code4096 >= DIV_LIMIT);

  // squaring result
  logic [31:0]         sq;
  logic [30:0]         m_next;
  logic [29:0]         frac_next;
  assign sq        = prod[61:30];
  assign m_next    = sq[31] ? sq[31:1] : sq[30:0];
  assign frac_next = {frac[28:0], sq[31]};

  // ln magnitude and sum
  logic [35:0]         lmag_next;
  logic [45:0]         tb;
  logic [63:0]         tsum;
  assign lmag_next = prod[61:26];
  assign tb        = prod[75:30];
  assign tsum      = 64'(tb) + 64'(td);

  // restoring division step
  logic [64:0]         rsh, rdiff;
  logic                ge;
  assign rsh   = {rem, dvd[63]};
  assign rdiff = rsh - {1'b0, dvs};
  assign ge    = (rsh >= {1'b0, dvs});

  logic [63:0]         smag;
  assign smag = s[63] ? (64'd0 - s) : s;

  logic signed [17:0]  t_pos, t_neg;
  logic [18:0]         t_pos_w, t_neg_w;
  assign t_pos_w = {1'b0, dvd[17:0]} - KELVIN_CENTI;
  assign t_neg_w = 19'd0 - ({1'b0, dvd[17:0]} + KELVIN_CENTI);
  assign t_pos   = t_pos_w[17:0];
  assign t_neg   = t_neg_w[17:0];

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      last_good_code <= 16'd0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ok <= in_data.read_ok;
            if (!sensor_ready) begin
              res_t <= 18'sd0;
              res_v <= 1'b0;
              state <= S_DONE;
            end else begin
              if (in_data.read_ok) begin
                last_good_code <= in_data.adc_code;
                code           <= in_data.adc_code;
              end else begin
                code <= last_good_code;
              end
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          if (special) begin
            res_t <= T_ABS_ZERO;
            state <= S_FIN;
          end else begin
            x     <= {1'b0, sc, 12'b0};
            den   <= DIV_LIMIT - code4096;
            k     <= 6'd47;
            which <= 1'b0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (x[47]) begin
            frac   <= 30'd0;
            icnt   <= 5'd0;
            mul_a  <= {17'b0, x[47:17]};
            mul_b  <= {17'b0, x[47:17]};
            mul_hi <= 48'd0;
            mcnt   <= 3'd0;
            ret    <= S_SQR;
            state  <= S_MUL;
          end else begin
            x <= {x[46:0], 1'b0};
            k <= k - 6'd1;
          end
        end
        S_MUL: begin
          mul_hi <= mul_sum[55:8];
          mul_lo <= {mul_sum[7:0], mul_lo[47:8]};
          mul_b  <= {8'b0, mul_b[47:8]};
          mcnt   <= mcnt + 3'd1;
          if (mcnt == 3'd5) state <= ret;
        end
        S_SQR: begin
          frac <= frac_next;
          icnt <= icnt + 5'd1;
          if (icnt == 5'd29) begin
            if (!which) begin
              lnum  <= {k, frac_next};
              x     <= {21'b0, den};
              k     <= 6'd47;
              which <= 1'b1;
              state <= S_NORM;
            end else begin
              lden  <= {k, frac_next};
              state <= S_LN;
            end
          end else begin
            mul_a  <= {17'b0, m_next};
            mul_b  <= {17'b0, m_next};
            mul_hi <= 48'd0;
            mcnt   <= 3'd0;
            ret    <= S_SQR;
            state  <= S_MUL;
          end
        end
        S_LN: begin
          neg    <= (lnum < lden);
          mul_a  <= {12'b0, (lnum < lden) ? (lden - lnum) : (lnum - lden)};
          mul_b  <= {22'b0, LN2_Q26};
          mul_hi <= 48'd0;
          mcnt   <= 3'd0;
          ret    <= S_LMAG;
          state  <= S_MUL;
        end
        S_LMAG: begin
          lmag   <= lmag_next;
          mul_a  <= {12'b0, lmag_next};
          mul_b  <= {12'b0, lmag_next};
          mul_hi <= 48'd0;
          mcnt   <= 3'd0;
          ret    <= S_L2;
          state  <= S_MUL;
        end
        S_L2: begin
          mul_a  <= prod[77:30];
          mul_b  <= {12'b0, lmag};
          mul_hi <= 48'd0;
          mcnt   <= 3'd0;
          ret    <= S_L3;
          state  <= S_MUL;
        end
        S_L3: begin
          mul_a  <= {8'b0, coef_d};
          mul_b  <= prod[77:30];
          mul_hi <= 48'd0;
          mcnt   <= 3'd0;
          ret    <= S_TD;
          state  <= S_MUL;
        end
        S_TD: begin
          td     <= prod[87:30];
          mul_a  <= {8'b0, coef_b};
          mul_b  <= {12'b0, lmag};
          mul_hi <= 48'd0;
          mcnt   <= 3'd0;
          ret    <= S_TB;
          state  <= S_MUL;
        end
        S_TB: begin
          s     <= neg ? (64'(coef_a) - tsum) : (64'(coef_a) + tsum);
          state <= S_SGN;
        end
        S_SGN: begin
          if (s == 64'd0) begin
            res_t <= T_OUT_MAX;
            state <= S_FIN;
          end else begin
            dvs   <= {smag[62:0], 1'b0};
            dvd   <= DIV_NUM_BASE + smag;
            rem   <= 64'd0;
            qcnt  <= 6'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? rdiff[63:0] : rsh[63:0];
          dvd  <= {dvd[62:0], ge};
          qcnt <= qcnt + 6'd1;
          if (qcnt == 6'd63) state <= S_QUOT;
        end
        S_QUOT: begin
          if (!s[63]) res_t <= (dvd > Q_POS_LIMIT) ? T_OUT_MAX : t_pos;
          else        res_t <= (dvd > Q_NEG_LIMIT) ? T_OUT_MIN : t_neg;
          state <= S_FIN;
        end
        S_FIN: begin
          res_v <= ok && (res_t > min_plausible) && (res_t < max_plausible);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                  <= 1'b1;
            out_data.temperature_centi <= res_t;
            out_data.valid_res         <= res_v;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_ntc_code_to_temperature_core.sv -----
// Regression bench for ntc_code_to_temperature_core: a thermistor code goes in, a temperature in
// hundredths of a degree comes out. An in-bench integer model predicts every beat.
// Depends on ntc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_ntc_code_to_temperature_core;
  import ntc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [39:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  ntc_code_to_temperature_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state and register copies
  logic               m_ready;
  logic [39:0]        m_a, m_b, m_d;
  logic [19:0]        m_series;
  logic signed [17:0] m_min, m_max;
  logic signed [15:0] m_last_code;

  out_item_t temp_queue[$];
  int  errors = 0;
  int  sent = 0;
  int  checked = 0;
  int  valid_seen = 0;
  int  send_gap_pct = 0;
  int  stall_pct = 0;
  bit  hold_off = 1'b0;

  function automatic logic [63:0] log2_q30(logic [63:0] x);
    int unsigned k;
    logic [63:0] m, frac;
    k = 0;
    frac = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(k) << 30) | frac;
  endfunction

  function automatic logic [63:0] mul_shr30(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[93:30];
  endfunction

  function automatic longint centi_of_code(logic signed [15:0] code);
    logic [63:0] lim, c4, num, den, lnum, lden, mag, lmag, l2, l3, tb, td, q, smag;
    logic neg;
    longint s;
    lim = 64'(DIV_LIMIT);
    if (code <= 0 || m_series == 0) return -27315;
    c4 = 64'(code) * 4096;
    if (c4 >= lim) return -27315;
    num = 64'(m_series) * c4;
    den = lim - c4;
    lnum = log2_q30(num);
    lden = log2_q30(den);
    neg = lnum < lden;
    mag = neg ? lden - lnum : lnum - lden;
    lmag = (mag * 64'(LN2_Q26)) >> 26;
    l2 = mul_shr30(lmag, lmag);
    l3 = mul_shr30(l2, lmag);
    tb = mul_shr30(64'(m_b), lmag);
    td = mul_shr30(64'(m_d), l3);
    s = neg ? longint'(m_a) - longint'(tb + td) : longint'(64'(m_a) + tb + td);
    if (s == 0) return 131071;
    smag = (s < 0) ? 64'(-s) : 64'(s);
    q = (DIV_NUM_BASE + smag) / (2 * smag);
    if (s > 0) return (q > 158386) ? 131071 : longint'(q) - 27315;
    return (q > 60083) ? -32768 : -longint'(q) - 27315;
  endfunction

  function automatic out_item_t predict_temp(in_item_t it);
    out_item_t r;
    longint t;
    r = '0;
    if (!m_ready) return r;
    if (it.read_ok) m_last_code = it.adc_code;
    t = centi_of_code(m_last_code);
    r.temperature_centi = 18'(t);
    r.valid_res = it.read_ok && t > m_min && t < m_max;
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [39:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_READY:  m_ready = val[0];
      REG_COEF_A: m_a = val;
      REG_COEF_B: m_b = val;
      REG_COEF_D: m_d = val;
      REG_SERIES: m_series = val[19:0];
      REG_MIN:    m_min = val[17:0];
      REG_MAX:    m_max = val[17:0];
      default: ;
    endcase
  endtask

  task automatic send_beat(logic signed [15:0] code, logic ok);
    in_item_t it;
    it.adc_code = code;
    it.read_ok = ok;
    // valid drops between beats
    @(posedge clk);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    temp_queue.push_back(predict_temp(it));
    sent++;
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (temp_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (700) @(posedge clk);
  endtask

  // receiver: random stall, or held off when asked
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (temp_queue.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        exp_r = temp_queue.pop_front();
        checked++;
        if (exp_r.valid_res) valid_seen++;
        if (out_data.temperature_centi !== exp_r.temperature_centi) begin
          $error("temperature_centi exp %0d got %0d", exp_r.temperature_centi,
                 out_data.temperature_centi);
          errors++;
        end
        if (out_data.valid_res !== exp_r.valid_res) begin
          $error("valid_res exp %0d got %0d", exp_r.valid_res, out_data.valid_res);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_code();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(32767));
      2: return 16'($urandom_range(26000, 1000));
      default: return 16'($urandom_range(26500, 26350));
    endcase
  endfunction

  task automatic test_not_ready();
    send_beat(16'sd12000, 1'b1);
    send_beat(-16'sd1, 1'b0);
    drain();
    write_reg(REG_READY, 40'd1);
    send_beat(16'sd0, 1'b0); // last good code still zero
    drain();
  endtask

  task automatic test_directed();
    send_beat(16'sd12000, 1'b1);
    send_beat(16'sd5, 1'b0);
    send_beat(16'sd0, 1'b1);
    send_beat(-16'sd32768, 1'b1);
    send_beat(16'sd32767, 1'b1);
    send_beat(16'sd26399, 1'b1);
    send_beat(16'sd26400, 1'b1);
    send_beat(16'sd1, 1'b1);
    send_beat(16'sd26000, 1'b1);
    send_beat(16'sd16000, 1'b1);
    drain();
    write_reg(REG_SERIES, 40'd0);
    send_beat(16'sd12000, 1'b1);
    drain();
    write_reg(REG_SERIES, 40'd1000000);
    write_reg(REG_MIN, 40'h3FFFF & -40'sd27315);
    write_reg(REG_MAX, 40'd131071);
    send_beat(16'sd100, 1'b1);
    send_beat(16'sd25000, 1'b1);
    drain();
    // negative and zero denominators
    write_reg(REG_COEF_A, 40'd0);
    send_beat(16'sd100, 1'b1);
    send_beat(16'sd20000, 1'b1);
    drain();
    write_reg(REG_COEF_B, 40'd0);
    write_reg(REG_COEF_D, 40'd0);
    send_beat(16'sd20000, 1'b1);
    drain();
    write_reg(REG_COEF_A, 40'hFF_FFFF_FFFF);
    write_reg(REG_COEF_B, 40'hFF_FFFF_FFFF);
    write_reg(REG_COEF_D, 40'hFF_FFFF_FFFF);
    send_beat(16'sd20000, 1'b1);
    send_beat(16'sd10, 1'b1);
    drain();
  endtask

  task automatic defaults();
    write_reg(REG_COEF_A, COEF_A_RST);
    write_reg(REG_COEF_B, COEF_B_RST);
    write_reg(REG_COEF_D, COEF_D_RST);
    write_reg(REG_SERIES, 40'(SERIES_RST));
    write_reg(REG_MIN, 40'(unsigned'(MIN_RST)));
    write_reg(REG_MAX, 40'(unsigned'(MAX_RST)));
    write_reg(REG_READY, 40'd1);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_beat(rand_code(), $urandom_range(9) != 0);
    end
    drain();
  endtask

  task automatic test_random_config();
    write_reg(REG_SERIES, 40'($urandom_range(1000000, 1)));
    write_reg(REG_COEF_A, {8'($urandom), 32'($urandom)} >> $urandom_range(4));
    write_reg(REG_COEF_B, {8'($urandom), 32'($urandom)} >> $urandom_range(12, 2));
    write_reg(REG_COEF_D, {8'($urandom), 32'($urandom)} >> $urandom_range(20, 10));
    write_reg(REG_MIN, 40'(18'($urandom_range(20000)) - 18'd10000));
    write_reg(REG_MAX, 40'(18'($urandom_range(60000))));
    test_random(40);
    write_reg(REG_READY, 40'd0);
    test_random(10);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_beat(rand_code(), 1'b1);
    join
    drain();
  endtask

  initial begin
    m_ready = 1'b0;
    m_a = COEF_A_RST;
    m_b = COEF_B_RST;
    m_d = COEF_D_RST;
    m_series = SERIES_RST;
    m_min = MIN_RST;
    m_max = MAX_RST;
    m_last_code = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_not_ready();
    test_directed();
    defaults();
    send_gap_pct = 13;
    stall_pct = 82;
    test_random(400);
    send_gap_pct = 82;
    stall_pct = 13;
    test_random(400);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random(350);
    for (int k = 0; k < 3; k++) test_random_config();
    defaults();
    test_backpressure();
    if (temp_queue.size() != 0) begin
      $error("%0d expected results never arrived", temp_queue.size());
      errors++;
    end
    $display("covered %0d beats, %0d results checked, %0d flagged valid", sent, checked,
             valid_seen);
    $display("directed extremes, failed reads, not-ready, coefficient sweeps, backpressure");
    if (errors == 0) begin
      $display("ntc_code_to_temperature_core regression: pass");
    end else begin
      $display("ntc_code_to_temperature_core regression: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("ntc_code_to_temperature_core regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ntc_pkg.sv
rtl/ntc_code_to_temperature_core.sv
sim/tb_ntc_code_to_temperature_core.sv
